// ===== rtl/core/dnv_pkg.sv =====
// Shared constants and helpers for the domain name validator.
package dnv_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PrefixLen = 8;
  localparam int unsigned PrefixPosW = $clog2(PrefixLen);

  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChSlash  = 8'h2f;
  localparam logic [CharW-1:0] ChBslash = 8'h5c;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChThree  = 8'h33;
  localparam logic [CharW-1:0] ChSeven  = 8'h37;
  localparam logic [CharW-1:0] ChPrintLo = 8'd33;
  localparam logic [CharW-1:0] ChPrintHi = 8'd126;
  localparam logic [CharW-1:0] OctLowMax  = 8'd32;
  localparam logic [CharW-1:0] OctHighMin = 8'd127;

  // Byte of the "<kernel>" prefix at a given position.
  function automatic logic [CharW-1:0] prefix_char(input logic [PrefixPosW-1:0] pos);
    logic [CharW-1:0] c;
    case (pos)
      3'd0:    c = 8'h3c;  // <
      3'd1:    c = 8'h6b;  // k
      3'd2:    c = 8'h65;  // e
      3'd3:    c = 8'h72;  // r
      3'd4:    c = 8'h6e;  // n
      3'd5:    c = 8'h65;  // e
      3'd6:    c = 8'h6c;  // l
      3'd7:    c = 8'h3e;  // >
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_octal(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChSeven);
  endfunction

endpackage

// ===== rtl/core/domain_name_validator.sv =====
// Domain name validator: byte-serial checker with a registered verdict.
//
//   channel | signals                       | moves
//   --------+-------------------------------+-----------------------------
//   in      | in_valid, in_ready, ch, last  | one byte of the name string
//   out     | out_valid, out_ready, accepted| one verdict per string
//
// One byte is taken per clock while in_ready is high; the checker state updates in the same cycle.
// The verdict lands in the output register in the cycle after the ending byte.
// in_ready drops only while a verdict waits in the output register and
// out_ready is low; bytes that produce no verdict still need that slot free.
// Synchronous reset clears the checker state and the output valid flag.
module domain_name_validator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dnv_pkg::CharW-1:0] ch,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      accepted
);
  import dnv_pkg::*;

  typedef enum logic [6:0] {
    PH_PREFIX = 7'b0000001,
    PH_OPEN   = 7'b0000010,
    PH_SLASH  = 7'b0000100,
    PH_NAME   = 7'b0001000,
    PH_ESC    = 7'b0010000,
    PH_OCT1   = 7'b0100000,
    PH_OCT2   = 7'b1000000
  } phase_t;

  phase_t                phase, phase_next;
  logic [PrefixPosW-1:0] prefix_pos, prefix_pos_next;
  logic [1:0]            octal_high, octal_high_next;
  logic [2:0]            octal_mid, octal_mid_next;
  logic                  failed, failed_next;
  logic                  draining, draining_next;
  logic                  emit;
  logic                  verdict;
  logic                  in_fire;
  logic [CharW-1:0]      oct_val;
  logic                  oct_ok;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign oct_val = {octal_high, octal_mid, ch[2:0]};
  assign oct_ok  = (oct_val != '0) && ((oct_val <= OctLowMax) || (oct_val >= OctHighMin));

  always_comb begin
    phase_next      = phase;
    prefix_pos_next = prefix_pos;
    octal_high_next = octal_high;
    octal_mid_next  = octal_mid;
    failed_next     = failed;
    draining_next   = draining;
    emit            = 1'b0;
    verdict         = 1'b0;
    if (in_fire) begin
      if (draining) begin
        if (last) begin
          draining_next = 1'b0;
        end
      end else begin
        if (ch != '0 && !failed) begin
          case (phase)
            PH_PREFIX: begin
              if (ch == prefix_char(prefix_pos)) begin
                if (prefix_pos == PrefixPosW'(PrefixLen - 1)) begin
                  phase_next      = PH_OPEN;
                  prefix_pos_next = '0;
                end else begin
                  prefix_pos_next = prefix_pos + 1'b1;
                end
              end else begin
                failed_next = 1'b1;
              end
            end
            PH_OPEN: begin
              if (ch == ChSpace) phase_next = PH_SLASH;
              else failed_next = 1'b1;
            end
            PH_SLASH: begin
              if (ch == ChSlash) phase_next = PH_NAME;
              else failed_next = 1'b1;
            end
            PH_NAME: begin
              if (ch == ChSpace) phase_next = PH_SLASH;
              else if (ch == ChBslash) phase_next = PH_ESC;
              else if (ch < ChPrintLo || ch > ChPrintHi) failed_next = 1'b1;
            end
            PH_ESC: begin
              if (ch == ChBslash) begin
                phase_next = PH_NAME;
              end else if (ch >= ChZero && ch <= ChThree) begin
                octal_high_next = ch[1:0];
                phase_next      = PH_OCT1;
              end else begin
                failed_next = 1'b1;
              end
            end
            PH_OCT1: begin
              if (is_octal(ch)) begin
                octal_mid_next = ch[2:0];
                phase_next     = PH_OCT2;
              end else begin
                failed_next = 1'b1;
              end
            end
            PH_OCT2: begin
              if (is_octal(ch) && oct_ok) phase_next = PH_NAME;
              else failed_next = 1'b1;
            end
            default: failed_next = 1'b1;
          endcase
        end
        // End of string: give the verdict and rearm for the next one.
        if (ch == '0 || last) begin
          emit    = 1'b1;
          verdict = !failed_next && (phase_next == PH_OPEN || phase_next == PH_NAME);
          phase_next      = PH_PREFIX;
          prefix_pos_next = '0;
          octal_high_next = '0;
          octal_mid_next  = '0;
          failed_next     = 1'b0;
          draining_next   = (ch == '0) && !last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PREFIX;
      prefix_pos <= '0;
      octal_high <= '0;
      octal_mid  <= '0;
      failed     <= 1'b0;
      draining   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      prefix_pos <= prefix_pos_next;
      octal_high <= octal_high_next;
      octal_mid  <= octal_mid_next;
      failed     <= failed_next;
      draining   <= draining_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      accepted <= verdict;
    end
  end

  // While dropping bytes after a zero byte the string state stays cleared.
  a_drain_clean: assert property (@(posedge clk) disable iff (rst)
    draining |-> (phase == PH_PREFIX && prefix_pos == '0 && !failed))
    else $error("string state not clear while draining");

  // A zero byte without last starts draining and produces a verdict.
  a_zero_drain: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !draining && ch == '0 && !last) |=> (draining && out_valid))
    else $error("zero byte did not start draining");

  // A request ending the string yields a verdict next cycle.
  a_last_verdict: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !draining && last) |=> out_valid)
    else $error("missing verdict after last byte");

  // Draining requests never produce a verdict.
  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && draining) |-> !emit)
    else $error("verdict produced while draining");

endmodule

// ===== sim/dnv_verdict_checker.sv =====
// Watches both channels of the name validator, predicts each verdict and compares it.
module dnv_verdict_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [dnv_pkg::CharW-1:0] ch,
  input  logic                      last,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      accepted,
  output int                        mismatches,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import dnv_pkg::*;

  typedef enum logic [6:0] {
    PhPrefix = 7'b0000001,
    PhOpen   = 7'b0000010,
    PhSlash  = 7'b0000100,
    PhName   = 7'b0001000,
    PhEsc    = 7'b0010000,
    PhOct1   = 7'b0100000,
    PhOct2   = 7'b1000000
  } name_phase_t;

  localparam logic [8*PrefixLen-1:0] KernelTag = "<kernel>";

  name_phase_t           phase;
  logic [PrefixPosW-1:0] tag_pos;
  logic [1:0]            oct_hi;
  logic [2:0]            oct_mid;
  logic                  rejected;
  logic                  skipping;
  logic                  verdict_q[$];

  function automatic void clear_name();
    phase    = PhPrefix;
    tag_pos  = '0;
    oct_hi   = '0;
    oct_mid  = '0;
    rejected = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [CharW-1:0] c);
    logic [CharW-1:0] code;
    case (phase)
      PhPrefix: begin
        if (c != KernelTag[8*(PrefixLen-1-int'(tag_pos)) +: 8]) begin
          rejected = 1'b1;
        end else if (tag_pos == PrefixPosW'(PrefixLen-1)) begin
          phase   = PhOpen;
          tag_pos = '0;
        end else begin
          tag_pos = tag_pos + 1'b1;
        end
      end
      PhOpen: begin
        if (c == ChSpace) phase = PhSlash;
        else rejected = 1'b1;
      end
      PhSlash: begin
        if (c == ChSlash) phase = PhName;
        else rejected = 1'b1;
      end
      PhName: begin
        if (c == ChSpace) phase = PhSlash;
        else if (c == ChBslash) phase = PhEsc;
        else if (c < ChPrintLo || c > ChPrintHi) rejected = 1'b1;
      end
      PhEsc: begin
        if (c == ChBslash) begin
          phase = PhName;
        end else if (c >= ChZero && c <= ChThree) begin
          oct_hi = c[1:0];
          phase  = PhOct1;
        end else begin
          rejected = 1'b1;
        end
      end
      PhOct1: begin
        if (c >= ChZero && c <= ChSeven) begin
          oct_mid = c[2:0];
          phase   = PhOct2;
        end else begin
          rejected = 1'b1;
        end
      end
      PhOct2: begin
        code = {oct_hi, oct_mid, c[2:0]};
        if (c >= ChZero && c <= ChSeven && code != '0
            && (code <= OctLowMax || code >= OctHighMin)) begin
          phase = PhName;
        end else begin
          rejected = 1'b1;
        end
      end
      default: rejected = 1'b1;
    endcase
  endfunction

  always @(posedge clk) begin
    logic exp_ok;
    if (rst) begin
      clear_name();
      skipping   = 1'b0;
      mismatches = 0;
      verdict_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (skipping) begin
          if (last) skipping = 1'b0;
        end else begin
          if (ch != '0 && !rejected) scan_byte(ch);
          // a zero byte or the last flag closes the string
          if (ch == '0 || last) begin
            verdict_q.push_back(!rejected && (phase == PhOpen || phase == PhName));
            clear_name();
            skipping = (ch == '0) && !last;
          end
        end
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] verdict %0b with no string pending", $realtime, accepted);
          mismatches++;
        end else begin
          exp_ok = verdict_q.pop_front();
          if (accepted !== exp_ok) begin
            if (mismatches < 10)
              $display("[%0t] accepted: expected %0b, got %0b", $realtime, exp_ok, accepted);
            mismatches++;
          end
        end
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the name validator: clock, reset, request stimulus and final verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dnv_pkg::*;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [CharW-1:0] ch;
  logic             last;
  logic             out_valid;
  logic             out_ready;
  logic             accepted;

  int               mismatches;
  int               outstanding;
  int               sent;
  bit               tx_steady;
  bit               rx_steady;
  bit               rx_long;
  logic [CharW-1:0] name_q[$];

  domain_name_validator DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .accepted  (accepted)
  );

  dnv_verdict_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .accepted    (accepted),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Present one request and hold it until taken; maybe idle afterwards.
  task automatic send_byte(input logic [CharW-1:0] c, input logic fin);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    ch       <= c;
    last     <= fin;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!tx_steady && $urandom_range(0, 3) == 0) begin
      gap = idle_len();
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_string();
    foreach (name_q[i]) send_byte(name_q[i], i == name_q.size() - 1);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) name_q.push_back(s[i]);
  endtask

  task automatic push_name_char();
    int pick;
    logic [CharW-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      do v = 8'($urandom_range(33, 126)); while (v == ChBslash);
      name_q.push_back(v);
    end else if (pick < 7) begin
      name_q.push_back(ChBslash);
      name_q.push_back(ChBslash);
    end else begin
      v = $urandom_range(0, 1) ? 8'($urandom_range(1, 32)) : 8'($urandom_range(127, 255));
      name_q.push_back(ChBslash);
      name_q.push_back(8'(ChZero + v[7:6]));
      name_q.push_back(8'(ChZero + v[5:3]));
      name_q.push_back(8'(ChZero + v[2:0]));
    end
  endtask

  task automatic build_name();
    int comps;
    int len;
    name_q.delete();
    push_text("<kernel>");
    comps = $urandom_range(0, 3);
    repeat (comps) begin
      name_q.push_back(ChSpace);
      name_q.push_back(ChSlash);
      len = $urandom_range(0, 5);
      repeat (len) push_name_char();
    end
  endtask

  // Spoil a well-formed name: stray byte, cut short, dangling space or a bad escape.
  task automatic break_name();
    int keep;
    case ($urandom_range(0, 3))
      0: name_q[$urandom_range(0, name_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        keep = $urandom_range(1, name_q.size());
        while (name_q.size() > keep) void'(name_q.pop_back());
      end
      2: name_q.push_back(ChSpace);
      default: begin
        if (name_q.size() == PrefixLen) push_text(" /");
        name_q.push_back(ChBslash);
        case ($urandom_range(0, 5))
          0: ;
          1: push_text("4");
          2: push_text("000");
          3: push_text("101");
          4: push_text("38");
          default: push_text("a");
        endcase
        if ($urandom_range(0, 1)) push_name_char();
      end
    endcase
  endtask

  // Sometimes close with a zero byte, at times followed by bytes that get dropped.
  task automatic add_ending();
    int tail;
    case ($urandom_range(0, 5))
      0: name_q.push_back('0);
      1: begin
        name_q.push_back('0);
        tail = $urandom_range(1, 4);
        repeat (tail) name_q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Response side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int wait_left;
    bit long_done;
    wait_left = 0;
    long_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (wait_left > 0) begin
        out_ready <= 1'b0;
        wait_left--;
      end else if (rx_long && !long_done) begin
        long_done = 1'b1;
        wait_left = 299;
        out_ready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        wait_left = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int str_idx;
    int kind;
    rst       = 1'b1;
    in_valid  = 1'b0;
    ch        = '0;
    last      = 1'b0;
    sent      = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rx_long   = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // empty string, zero byte with dropped tail, then a name with both escape kinds
    name_q = '{8'h00};
    send_string();
    name_q = '{8'h00, 8'hff, 8'h00};
    send_string();
    name_q.delete();
    push_text("<kernel> /!~\\\\\\377");
    send_string();
    hold_until_drained();

    str_idx = 0;
    while (sent < 1000) begin
      str_idx++;
      tx_steady = (str_idx % 12) >= 4 && (str_idx % 12) <= 6;
      rx_steady = (str_idx % 10) >= 6 && (str_idx % 10) <= 8;
      if (str_idx == 8) rx_long = 1'b1;
      if (str_idx % 15 == 0) hold_until_drained();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        name_q.delete();
        repeat ($urandom_range(1, 12)) name_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_name();
        if (kind <= 3) break_name();
        add_ending();
      end
      send_string();
    end

    hold_until_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
